// ===== rtl/lvt_pkg.sv =====
// Shared constants and types for the 3D line voxel traversal block.
// Used by the controller, the datapath and the top level; no dependencies.
`timescale 1ns / 1ps

package lvt_pkg;

  // Width of one voxel coordinate within the tile
  localparam int COORD_BITS = 6;
  // Signed error term width: holds +/- four times the largest delta
  localparam int ERR_BITS   = COORD_BITS + 3;

  // Stream payload widths, packed fields rounded up to whole bytes
  localparam int IN_TDATA_W  = ((6 * COORD_BITS + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((3 * COORD_BITS + 7) / 8) * 8;

  typedef logic [COORD_BITS-1:0]      coord_t;
  typedef logic signed [ERR_BITS-1:0] err_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SETUP,
    ST_EMIT
  } lvt_state_t;

  // Controller to datapath
  typedef struct packed {
    logic load;   // latch start and end of a new segment
    logic setup;  // derive deltas, driving axis and error terms
    logic step;   // advance one voxel along the line
  } lvt_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic last;   // current voxel is the end point
  } lvt_status_t;

endpackage

// ===== rtl/lvt_ctrl.sv =====
// Controller state machine for the 3D line voxel traversal block.
// Depends on lvt_pkg; drives the datapath by command and reads its status.
`timescale 1ns / 1ps

module lvt_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  output logic                out_tvalid,
  input  logic                out_tready,
  input  lvt_pkg::lvt_status_t status,
  output lvt_pkg::lvt_cmd_t    cmd
);
  import lvt_pkg::*;

  lvt_state_t state_r;
  lvt_state_t state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    in_tready  = 1'b0;
    out_tvalid = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_SETUP;
        end
      end
      ST_SETUP: begin
        cmd.setup = 1'b1;
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        out_tvalid = 1'b1;
        // advance only once the current voxel has been taken
        if (out_tready) begin
          if (status.last) begin
            state_nxt = ST_IDLE;
          end else begin
            cmd.step = 1'b1;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/lvt_dp.sv =====
// Datapath for the 3D line voxel traversal block: positions, deltas,
// error terms and step counter. Depends on lvt_pkg; commanded by lvt_ctrl.
`timescale 1ns / 1ps

module lvt_dp (
  input  logic                 clk,
  input  lvt_pkg::lvt_cmd_t    cmd,
  input  lvt_pkg::coord_t      start_x,
  input  lvt_pkg::coord_t      start_y,
  input  lvt_pkg::coord_t      start_z,
  input  lvt_pkg::coord_t      end_x,
  input  lvt_pkg::coord_t      end_y,
  input  lvt_pkg::coord_t      end_z,
  output lvt_pkg::coord_t      vox_x,
  output lvt_pkg::coord_t      vox_y,
  output lvt_pkg::coord_t      vox_z,
  output lvt_pkg::lvt_status_t status
);
  import lvt_pkg::*;

  localparam int PAD = ERR_BITS - COORD_BITS - 1;

  coord_t pos_r [3];
  coord_t pos_nxt [3];
  coord_t end_r [3];
  coord_t dlt_r [3];
  coord_t dlt_c [3];
  logic   up_r [3];
  logic   up_c [3];
  err_t   err_r [3];
  err_t   err_nxt [3];
  err_t   err_c [3];
  logic [2:0] drive_r;
  logic [2:0] drive_c;
  coord_t steps_r;
  coord_t steps_c;
  coord_t rem_r;
  err_t   two_steps;

  // Setup: per-axis direction and absolute delta
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      up_c[a]  = pos_r[a] < end_r[a];
      dlt_c[a] = up_c[a] ? (end_r[a] - pos_r[a]) : (pos_r[a] - end_r[a]);
    end
  end

  // Setup: driving axis, ties go to the lower axis
  always_comb begin
    priority if (dlt_c[0] >= dlt_c[1] && dlt_c[0] >= dlt_c[2]) begin
      drive_c = 3'b001;
      steps_c = dlt_c[0];
    end else if (dlt_c[1] >= dlt_c[2]) begin
      drive_c = 3'b010;
      steps_c = dlt_c[1];
    end else begin
      drive_c = 3'b100;
      steps_c = dlt_c[2];
    end
  end

  // Setup: initial error terms, 2*d - steps
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      err_c[a] = $signed({{PAD{1'b0}}, dlt_c[a], 1'b0})
               - $signed({1'b0, {PAD{1'b0}}, steps_c});
    end
  end

  assign two_steps = $signed({{PAD{1'b0}}, steps_r, 1'b0});

  // Step: driving axis always moves, others move on non-negative error
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      pos_nxt[a] = pos_r[a];
      err_nxt[a] = err_r[a];
      if (drive_r[a]) begin
        pos_nxt[a] = up_r[a] ? pos_r[a] + 1'b1 : pos_r[a] - 1'b1;
      end else begin
        if (err_r[a] >= 0) begin
          pos_nxt[a] = up_r[a] ? pos_r[a] + 1'b1 : pos_r[a] - 1'b1;
          err_nxt[a] = err_r[a] - two_steps + $signed({{PAD{1'b0}}, dlt_r[a], 1'b0});
        end else begin
          err_nxt[a] = err_r[a] + $signed({{PAD{1'b0}}, dlt_r[a], 1'b0});
        end
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      pos_r[0] <= start_x;
      pos_r[1] <= start_y;
      pos_r[2] <= start_z;
      end_r[0] <= end_x;
      end_r[1] <= end_y;
      end_r[2] <= end_z;
    end else if (cmd.setup) begin
      for (int a = 0; a < 3; a++) begin
        up_r[a]  <= up_c[a];
        dlt_r[a] <= dlt_c[a];
        err_r[a] <= err_c[a];
      end
      drive_r <= drive_c;
      steps_r <= steps_c;
      rem_r   <= steps_c;
    end else if (cmd.step) begin
      for (int a = 0; a < 3; a++) begin
        pos_r[a] <= pos_nxt[a];
        err_r[a] <= err_nxt[a];
      end
      rem_r <= rem_r - 1'b1;
    end
  end

  assign vox_x       = pos_r[0];
  assign vox_y       = pos_r[1];
  assign vox_z       = pos_r[2];
  assign status.last = (rem_r == '0);

endmodule

// ===== rtl/line_voxel_traversal_3d.sv =====
// Top level of the 3D line voxel traversal block.
// Depends on lvt_pkg, lvt_ctrl and lvt_dp.
//
// Usage:
//   The input stream carries one segment per transaction: start and end
//   voxel coordinates inside the tile. The output stream carries every
//   voxel of the 3D Bresenham line from start to end, one per
//   transaction, with out_tlast high on the end point. A zero-length
//   segment gives a single voxel with out_tlast high.
//   Timing: after a segment is accepted, a setup state derives the
//   deltas and driving axis; the first voxel is presented in the next
//   cycle and then one voxel per cycle while out_tready is high. A
//   segment of n steps gives n + 1 voxels, all from the single
//   stepping unit; the block returns to idle after the last is taken.
//   One segment is handled at a time: in_tready is high only when the
//   block is idle. When the receiver stalls, the current voxel is held
//   on out_tdata and out_tlast until taken.
//   Reset (rst_n low, synchronous) returns the block to idle and drops
//   any segment in progress.
`timescale 1ns / 1ps

module line_voxel_traversal_3d (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // start_x, start_y, start_z, end_x, end_y, end_z, zero fill
  input  logic [lvt_pkg::IN_TDATA_W-1:0]  in_tdata,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // vox_x, vox_y, vox_z, zero fill
  output logic [lvt_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic                            out_tlast
);
  import lvt_pkg::*;

  localparam int CB = COORD_BITS;

  lvt_cmd_t    cmd;
  lvt_status_t status;
  coord_t      vox_x;
  coord_t      vox_y;
  coord_t      vox_z;

  lvt_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .status     (status),
    .cmd        (cmd)
  );

  lvt_dp u_dp (
    .clk     (clk),
    .cmd     (cmd),
    .start_x (in_tdata[0*CB +: CB]),
    .start_y (in_tdata[1*CB +: CB]),
    .start_z (in_tdata[2*CB +: CB]),
    .end_x   (in_tdata[3*CB +: CB]),
    .end_y   (in_tdata[4*CB +: CB]),
    .end_z   (in_tdata[5*CB +: CB]),
    .vox_x   (vox_x),
    .vox_y   (vox_y),
    .vox_z   (vox_z),
    .status  (status)
  );

  // Pack the voxel, zero fill above
  assign out_tdata = {{(OUT_TDATA_W - 3*CB){1'b0}}, vox_z, vox_y, vox_x};
  assign out_tlast = status.last;

`ifndef ASSERT_OFF
  // No new segment is taken while a voxel is on offer
  a_one_segment: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready)
    else $error("segment accepted while voxels pending");

  // The setup cycle follows every accepted segment
  a_setup_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (!out_tvalid && !in_tready))
    else $error("no setup cycle after segment accept");

  // Delivering the end point frees the block
  a_last_frees: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && out_tlast) |=> (in_tready && !out_tvalid))
    else $error("block not idle after last voxel");

  // A taken voxel that is not the end point is followed by another
  a_more_voxels: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && !out_tlast) |=> out_tvalid)
    else $error("voxel stream ended without last");
`endif

endmodule

// ===== tb/tb_line_voxel_traversal_3d.sv =====
// Self-checking testbench for line_voxel_traversal_3d: directed segments, then random ones.
// Every voxel on the output stream is compared with a local 3D Bresenham line tracer.
// Depends on lvt_pkg and line_voxel_traversal_3d.
`timescale 1ns / 1ps

module tb_line_voxel_traversal_3d;

  localparam int CB       = lvt_pkg::COORD_BITS;
  localparam int RAND_SEGS = 240;
  localparam int PLAN_ROWS = 21;

  typedef lvt_pkg::coord_t coord_t;

  typedef struct packed {
    coord_t sx, sy, sz;
    coord_t ex, ey, ez;
  } segment_t;

  typedef struct packed {
    coord_t x, y, z;
    logic   last;
  } voxel_t;

  // One directed row: a segment and, where obvious, its voxel count (0: trace only)
  typedef struct packed {
    segment_t   seg;
    logic [6:0] n_vox;
  } plan_row_t;

  logic                            clk;
  logic                            rst_n;
  logic                            in_tvalid;
  logic                            in_tready;
  logic [lvt_pkg::IN_TDATA_W-1:0]  in_tdata;
  logic                            out_tvalid;
  logic                            out_tready;
  logic [lvt_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic                            out_tlast;

  voxel_t voxels_due[$];
  int     mismatches = 0;
  bit     calm       = 1'b0;
  bit     hold_off   = 1'b0;

  line_voxel_traversal_3d uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  // Free-running clock, 20 ns period
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Trace the line of one segment and queue every voxel it visits; return the count
  function automatic int trace_line(input segment_t seg);
    int     pos [3];
    int     tgt [3];
    int     dir [3];
    int     dlt [3];
    int     err [3];
    int     drive;
    int     steps;
    int     i;
    int     a;
    voxel_t v;
    pos[0] = seg.sx; pos[1] = seg.sy; pos[2] = seg.sz;
    tgt[0] = seg.ex; tgt[1] = seg.ey; tgt[2] = seg.ez;
    for (a = 0; a < 3; a++) begin
      dir[a] = (pos[a] < tgt[a]) ? 1 : -1;
      dlt[a] = (pos[a] < tgt[a]) ? tgt[a] - pos[a] : pos[a] - tgt[a];
    end
    // x wins ties over y and z, y wins over z
    if (dlt[0] >= dlt[1] && dlt[0] >= dlt[2]) drive = 0;
    else if (dlt[1] >= dlt[2])                drive = 1;
    else                                      drive = 2;
    steps = dlt[drive];
    for (a = 0; a < 3; a++) err[a] = 2 * dlt[a] - steps;
    v.x = coord_t'(pos[0]);
    v.y = coord_t'(pos[1]);
    v.z = coord_t'(pos[2]);
    v.last = (steps == 0);
    voxels_due = {voxels_due, v};
    for (i = 0; i < steps; i++) begin
      for (a = 0; a < 3; a++) begin
        if (a == drive) begin
          pos[a] += dir[a];
        end else begin
          if (err[a] >= 0) begin
            pos[a] += dir[a];
            err[a] -= 2 * steps;
          end
          err[a] += 2 * dlt[a];
        end
      end
      v.x = coord_t'(pos[0]);
      v.y = coord_t'(pos[1]);
      v.z = coord_t'(pos[2]);
      v.last = (i == steps - 1);
      voxels_due = {voxels_due, v};
    end
    return steps + 1;
  endfunction

  // Directed segments: extremes, every driving axis, ties and zero length
  function automatic plan_row_t plan_row(input int idx);
    plan_row_t r;
    case (idx)
      0:  r = '{'{0, 0, 0, 0, 0, 0}, 1};
      1:  r = '{'{63, 63, 63, 63, 63, 63}, 1};
      2:  r = '{'{0, 0, 0, 63, 0, 0}, 64};
      3:  r = '{'{63, 0, 0, 0, 0, 0}, 64};
      4:  r = '{'{0, 0, 0, 0, 63, 0}, 64};
      5:  r = '{'{0, 63, 0, 0, 0, 0}, 64};
      6:  r = '{'{0, 0, 0, 0, 0, 63}, 64};
      7:  r = '{'{0, 0, 63, 0, 0, 0}, 64};
      8:  r = '{'{0, 0, 0, 63, 63, 63}, 64};
      9:  r = '{'{63, 63, 63, 0, 0, 0}, 64};
      10: r = '{'{0, 63, 0, 63, 0, 63}, 64};
      11: r = '{'{63, 0, 63, 0, 63, 0}, 64};
      12: r = '{'{0, 0, 0, 10, 10, 3}, 11};
      13: r = '{'{0, 0, 0, 2, 20, 20}, 21};
      14: r = '{'{5, 5, 5, 25, 9, 25}, 21};
      15: r = '{'{1, 2, 3, 40, 17, 9}, 0};
      16: r = '{'{30, 0, 60, 25, 50, 40}, 0};
      17: r = '{'{10, 50, 0, 0, 40, 63}, 0};
      18: r = '{'{42, 21, 42, 21, 42, 21}, 0};
      19: r = '{'{7, 7, 7, 8, 7, 7}, 2};
      default: r = '{'{32, 31, 16, 31, 32, 47}, 0};
    endcase
    return r;
  endfunction

  // Move a coordinate by up to span either way, clamped to the tile
  function automatic coord_t nudge(input coord_t c, input int span);
    int v;
    v = int'(c) + $urandom_range(0, 2 * span) - span;
    if (v < 0)  v = 0;
    if (v > 63) v = 63;
    return coord_t'(v);
  endfunction

  // Random segment: mostly short or arbitrary lines, with axis-only, tied and corner cases
  function automatic segment_t random_segment();
    segment_t g;
    int       kind;
    int       d;
    g.sx = coord_t'($urandom); g.sy = coord_t'($urandom); g.sz = coord_t'($urandom);
    g.ex = coord_t'($urandom); g.ey = coord_t'($urandom); g.ez = coord_t'($urandom);
    kind = $urandom_range(0, 9);
    case (kind)
      4, 5, 6: begin
        g.ex = nudge(g.sx, 6);
        g.ey = nudge(g.sy, 6);
        g.ez = nudge(g.sz, 6);
      end
      7: begin
        // mostly a single moving axis, else x and z move together
        if ($urandom_range(0, 1)) g.ey = g.sy; else g.ex = g.sx;
        if ($urandom_range(0, 1)) g.ez = g.sz; else g.ey = g.sy;
      end
      8: begin
        if ($urandom_range(0, 2) == 0) begin
          g.ex = g.sx; g.ey = g.sy; g.ez = g.sz;
        end else begin
          // tie between two axes
          d = $urandom_range(0, 31);
          g.sx = coord_t'($urandom_range(0, 31));
          g.sy = coord_t'($urandom_range(0, 31));
          g.ex = g.sx + coord_t'(d);
          g.ey = g.sy + coord_t'(d);
          g.ez = nudge(g.sz, d / 2);
        end
      end
      9: begin
        g.sx = $urandom_range(0, 1) ? 6'd63 : 6'd0;
        g.sy = $urandom_range(0, 1) ? 6'd63 : 6'd0;
        g.sz = $urandom_range(0, 1) ? 6'd63 : 6'd0;
        g.ex = $urandom_range(0, 1) ? 6'd63 : 6'd0;
        g.ey = $urandom_range(0, 1) ? 6'd63 : 6'd0;
        g.ez = $urandom_range(0, 1) ? 6'd63 : 6'd0;
      end
      default: ;
    endcase
    return g;
  endfunction

  // Offer one segment after a random gap, optionally after draining; return voxels traced
  task automatic send_segment(input segment_t seg, input bit drain, output int n_vox);
    int                             gap;
    logic [lvt_pkg::IN_TDATA_W-1:0] word;
    gap = calm ? 0 : $urandom_range(0, 5);
    if (gap > 0 || drain) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
      if (drain) begin
        do @(posedge clk); while (voxels_due.size() != 0);
      end
    end
    word = '0;
    word[6*CB-1:0] = {seg.ez, seg.ey, seg.ex, seg.sz, seg.sy, seg.sx};
    in_tdata  <= word;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    n_vox = trace_line(seg);
  endtask

  // Compare one received voxel with the oldest expectation
  task automatic check_voxel(input voxel_t got);
    voxel_t want;
    if (voxels_due.size() == 0) begin
      $error("unexpected voxel x=%0d y=%0d z=%0d last=%0b", got.x, got.y, got.z, got.last);
      mismatches++;
    end else begin
      want = voxels_due.pop_front();
      if (got.x !== want.x) begin
        $error("vox_x: expected %0d, got %0d", want.x, got.x);
        mismatches++;
      end
      if (got.y !== want.y) begin
        $error("vox_y: expected %0d, got %0d", want.y, got.y);
        mismatches++;
      end
      if (got.z !== want.z) begin
        $error("vox_z: expected %0d, got %0d", want.z, got.z);
        mismatches++;
      end
      if (got.last !== want.last) begin
        $error("last: expected %0b, got %0b", want.last, got.last);
        mismatches++;
      end
    end
  endtask

  // Receiver: random back-pressure per voxel, one long hold-off on request
  initial begin
    int     gap;
    voxel_t got;
    out_tready = 1'b0;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      gap = calm ? 0 : $urandom_range(0, 5);
      if (hold_off) begin
        hold_off = 1'b0;
        gap = 300;
      end
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      got.x    = out_tdata[CB-1:0];
      got.y    = out_tdata[2*CB-1:CB];
      got.z    = out_tdata[3*CB-1:2*CB];
      got.last = out_tlast;
      check_voxel(got);
    end
  end

  // Stimulus: reset, directed table, random segments, drain and verdict
  initial begin
    plan_row_t row;
    segment_t  seg;
    int        n_vox;
    int        k;
    int        settle;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    for (k = 0; k < PLAN_ROWS; k++) begin
      row = plan_row(k);
      send_segment(row.seg, 1'b0, n_vox);
      if (row.n_vox != 0 && n_vox != int'(row.n_vox)) begin
        $error("voxel count of row %0d: expected %0d, traced %0d", k, row.n_vox, n_vox);
        mismatches++;
      end
    end

    for (k = 0; k < RAND_SEGS; k++) begin
      calm = ((k / 40) % 3 == 2);
      // stall the receiver for a long stretch while segments keep coming
      if (k == 60) hold_off = 1'b1;
      seg = random_segment();
      send_segment(seg, (k == 0 || k == 150), n_vox);
    end
    calm = 1'b0;
    in_tvalid <= 1'b0;

    // Drain outstanding voxels, then allow for stray ones
    while (voxels_due.size() != 0) @(posedge clk);
    settle = 0;
    while (settle < 20) begin
      @(posedge clk);
      settle++;
    end
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Timeout
  initial begin
    #20_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/lvt_pkg.sv
rtl/lvt_ctrl.sv
rtl/lvt_dp.sv
rtl/line_voxel_traversal_3d.sv
tb/tb_line_voxel_traversal_3d.sv
